// ===== rtl/core/mfhe_pkg.sv =====
// mfhe_pkg: shared types, constants and helper functions for the modbus frame hex encoder
// no dependencies; imported by every module of the block except mfhe_checker

package mfhe_pkg;

    localparam int unsigned PREFIX_LEN    = 11;
    localparam int unsigned CHARS_BIT     = 33;
    localparam int unsigned CHARS_REG     = 35;
    localparam int unsigned FRAME_LEN_BIT = 8;
    localparam int unsigned FRAME_LEN_REG = 9;
    localparam int unsigned IDX_W         = 6;
    localparam int unsigned BYTE_IDX_W    = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FN_BIT   = 8'h45;
    localparam logic [7:0]  FN_REG   = 8'h46;
    localparam logic [7:0]  ASCII_CR = 8'h0D;
    localparam logic [7:0]  ASCII_LF = 8'h0A;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] address;
        logic        mode;
    } item_t;

    typedef struct packed {
        logic       last;
        logic [7:0] char_out;
    } char_t;

    // one byte of crc-16/modbus, bit by bit, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = 8'h30 + {4'h0, nib};
        else
            ch = 8'h37 + {4'h0, nib};
        return ch;
    endfunction

    // "AT+NMGS=1" then mode digit then comma
    function automatic logic [7:0] prefix_char(input logic [3:0] i, input logic mode);
        logic [7:0] ch;
        case (i)
            4'd0:    ch = 8'h41;
            4'd1:    ch = 8'h54;
            4'd2:    ch = 8'h2B;
            4'd3:    ch = 8'h4E;
            4'd4:    ch = 8'h4D;
            4'd5:    ch = 8'h47;
            4'd6:    ch = 8'h53;
            4'd7:    ch = 8'h3D;
            4'd8:    ch = 8'h31;
            4'd9:    ch = mode ? 8'h31 : 8'h30;
            default: ch = 8'h2C;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/mfhe_in_buf.sv =====
// mfhe_in_buf: one-deep holding register for incoming requests
// depends on mfhe_pkg

module mfhe_in_buf
    import mfhe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  buf_valid,
    input  logic  buf_take,
    output item_t buf_item
);

    logic  full_reg;
    logic  full_next;
    item_t item_reg;

    assign in_ready  = !full_reg;
    assign buf_valid = full_reg;
    assign buf_item  = item_reg;

    always_comb
    begin
        full_next = full_reg;
        if (buf_take)
            full_next = 1'b0;
        if (in_valid && !full_reg)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !full_reg)
            item_reg <= in_item;
    end

endmodule

// ===== rtl/core/mfhe_char_gen.sv =====
// mfhe_char_gen: character sequencer with running crc, one character per cycle while ch_ready is high
// depends on mfhe_pkg

module mfhe_char_gen
    import mfhe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  buf_valid,
    output logic  buf_take,
    input  item_t buf_item,
    output logic  ch_valid,
    input  logic  ch_ready,
    output char_t ch
);

    logic                  active_reg;
    logic                  active_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [15:0]           crc_reg;
    logic [15:0]           crc_next;
    item_t                 item_reg;

    logic [IDX_W-1:0]      n_chars;
    logic [IDX_W-1:0]      pos;
    logic [BYTE_IDX_W-1:0] bi;
    logic [BYTE_IDX_W-1:0] flen;
    logic [7:0]            frame_byte;
    logic [7:0]            cur_byte;
    logic                  in_prefix;
    logic                  is_last;
    logic                  fire;

    function automatic logic [7:0] body_byte(input item_t it, input logic [BYTE_IDX_W-1:0] k);
        logic [7:0] b;
        case (k)
            4'd0:    b = 8'h01;
            4'd1:    b = it.mode ? FN_REG : FN_BIT;
            4'd2:    b = it.address[15:8];
            4'd3:    b = it.address[7:0];
            4'd4:    b = 8'h00;
            4'd5:    b = 8'h01;
            4'd6:    b = it.mode ? 8'h02 : 8'h01;
            4'd7:    b = it.mode ? it.value[15:8] : it.value[7:0];
            default: b = it.value[7:0];
        endcase
        return b;
    endfunction

    assign n_chars   = item_reg.mode ? IDX_W'(CHARS_REG) : IDX_W'(CHARS_BIT);
    assign flen      = item_reg.mode ? BYTE_IDX_W'(FRAME_LEN_REG) : BYTE_IDX_W'(FRAME_LEN_BIT);
    assign pos       = idx_reg - IDX_W'(PREFIX_LEN);
    assign bi        = pos[BYTE_IDX_W:1];
    assign in_prefix = idx_reg < IDX_W'(PREFIX_LEN);
    assign is_last   = idx_reg == n_chars - IDX_W'(1);
    assign frame_byte = body_byte(item_reg, bi);

    always_comb
    begin
        if (bi == flen)
            cur_byte = crc_reg[7:0];
        else if (bi == flen + BYTE_IDX_W'(1))
            cur_byte = crc_reg[15:8];
        else
            cur_byte = frame_byte;
    end

    always_comb
    begin
        ch.last = is_last;
        if (in_prefix)
            ch.char_out = prefix_char(idx_reg[3:0], item_reg.mode);
        else if (is_last)
            ch.char_out = ASCII_LF;
        else if (idx_reg == n_chars - IDX_W'(2))
            ch.char_out = ASCII_CR;
        else if (pos[0])
            ch.char_out = hex_char(cur_byte[3:0]);
        else
            ch.char_out = hex_char(cur_byte[7:4]);
    end

    assign ch_valid = active_reg;
    assign fire     = active_reg && ch_ready;
    assign buf_take = buf_valid && (!active_reg || (fire && is_last));

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        if (fire)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (!in_prefix && pos[0] && bi < flen)
                crc_next = crc16_byte(crc_reg, frame_byte);
            if (is_last)
                active_next = 1'b0;
        end
        if (buf_take)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            crc_next    = CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (buf_take)
            item_reg <= buf_item;
    end

endmodule

// ===== rtl/core/mfhe_out_reg.sv =====
// mfhe_out_reg: registered output stage of the character stream
// depends on mfhe_pkg

module mfhe_out_reg
    import mfhe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  ch_valid,
    output logic  ch_ready,
    input  char_t ch,
    output logic  out_valid,
    input  logic  out_ready,
    output char_t out_ch
);

    logic  valid_reg;
    logic  valid_next;
    char_t ch_reg;

    assign ch_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_ch    = ch_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ch_ready)
            valid_next = ch_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ch_ready && ch_valid)
            ch_reg <= ch;
    end

endmodule

// ===== rtl/core/modbus_frame_hex_encoder.sv =====
// modbus_frame_hex_encoder: builds a modbus-style frame with crc-16 and streams it as an
// ascii AT command line; depends on mfhe_pkg, mfhe_in_buf, mfhe_char_gen, mfhe_out_reg
//
//   channel   dir  handshake          payload
//   s_axis    in   s_tvalid/s_tready  s_tdata: mode, address, value
//   m_axis    out  m_tvalid/m_tready  m_tdata: char_out; m_tlast: last
//
// one character per cycle: 33 characters per bit-mode line, 35 per register-mode line,
// set by the character sequencer, which sends one word each cycle unless m_tready stalls it
// a one-deep input buffer takes the next request while the current line is streaming
// the crc advances one frame byte per two characters in the sequencer
// reset clears all valid flags; m_tready low holds the output word and stalls the sequencer

module modbus_frame_hex_encoder
    import mfhe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode, address, value, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_out
    output logic        m_tlast
);

    item_t in_item;
    item_t buf_item;
    char_t gen_ch;
    char_t out_ch;
    logic  buf_valid;
    logic  buf_take;
    logic  gen_valid;
    logic  gen_ready;

    assign in_item.mode    = s_tdata[0];
    assign in_item.address = s_tdata[16:1];
    assign in_item.value   = s_tdata[32:17];

    mfhe_in_buf u_in_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .buf_valid (buf_valid),
        .buf_take  (buf_take),
        .buf_item  (buf_item)
    );

    mfhe_char_gen u_char_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .buf_valid (buf_valid),
        .buf_take  (buf_take),
        .buf_item  (buf_item),
        .ch_valid  (gen_valid),
        .ch_ready  (gen_ready),
        .ch        (gen_ch)
    );

    mfhe_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch_valid  (gen_valid),
        .ch_ready  (gen_ready),
        .ch        (gen_ch),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ch    (out_ch)
    );

    assign m_tdata = out_ch.char_out;
    assign m_tlast = out_ch.last;

endmodule

// ===== rtl/core/mfhe_checker.sv =====
// mfhe_checker: port-level assertions for the modbus frame hex encoder
// no package dependencies; bound to modbus_frame_hex_encoder

module mfhe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    // last word of a line is always the line feed
    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == 8'h0A)
        else $error("tlast on a word other than line feed");

    // line feed appears only at the end of a line
    a_lf_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata == 8'h0A |-> m_tlast)
        else $error("line feed without tlast");

    // one-deep input buffer is full right after an accept
    a_in_one_deep: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

endmodule

bind modbus_frame_hex_encoder mfhe_checker u_mfhe_checker (.*);

// ===== sim/tb_modbus_frame_hex_encoder.sv =====
// tb_modbus_frame_hex_encoder: self-checking bench for the modbus frame hex encoder
// predicts every character of each AT command line and checks it against m_tdata/m_tlast
// depends on mfhe_pkg and modbus_frame_hex_encoder

module tb_modbus_frame_hex_encoder;
    import mfhe_pkg::*;

    localparam logic MODE_BIT = 1'b0;
    localparam logic MODE_REG = 1'b1;
    localparam int   RANDOM_PER_PHASE = 100;
    localparam int   TAIL_CYCLES = 40;
    localparam string HEX_DIGITS = "0123456789ABCDEF";
    localparam string AT_HEAD_BIT = "AT+NMGS=10,";
    localparam string AT_HEAD_REG = "AT+NMGS=11,";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // mode, address, value, zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // char_out
    logic        m_tlast;

    item_t request_q[$];
    char_t line_q[$];

    logic s_fire = 1'b0;
    logic m_fire = 1'b0;
    bit   send_idle = 1'b1;
    bit   recv_idle = 1'b1;
    int   gap_left = 0;
    int   stall_left = 0;
    int   errors = 0;
    int   chars_seen = 0;
    int   lines_bit = 0;
    int   lines_reg = 0;

    modbus_frame_hex_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] crc_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    // queue the expected characters of one command line
    function automatic void encode_line(input item_t req);
        logic [7:0]  frame [0:10];
        int          nbytes;
        logic [15:0] crc;
        string       head;
        char_t       ch;
        frame[0] = 8'h01;
        frame[1] = (req.mode == MODE_REG) ? FN_REG : FN_BIT;
        frame[2] = req.address[15:8];
        frame[3] = req.address[7:0];
        frame[4] = 8'h00;
        frame[5] = 8'h01;
        if (req.mode == MODE_REG)
        begin
            frame[6] = 8'h02;
            frame[7] = req.value[15:8];
            frame[8] = req.value[7:0];
            nbytes = 9;
            head = AT_HEAD_REG;
        end
        else
        begin
            frame[6] = 8'h01;
            frame[7] = req.value[7:0];
            nbytes = 8;
            head = AT_HEAD_BIT;
        end
        crc = 16'hFFFF;
        for (int i = 0; i < nbytes; i++)
            crc = crc_modbus_step(crc, frame[i]);
        frame[nbytes] = crc[7:0];
        frame[nbytes + 1] = crc[15:8];
        nbytes += 2;
        ch.last = 1'b0;
        for (int i = 0; i < head.len(); i++)
        begin
            ch.char_out = head[i];
            line_q.push_back(ch);
        end
        for (int i = 0; i < nbytes; i++)
        begin
            ch.char_out = HEX_DIGITS[frame[i][7:4]];
            line_q.push_back(ch);
            ch.char_out = HEX_DIGITS[frame[i][3:0]];
            line_q.push_back(ch);
        end
        ch.char_out = 8'h0D;
        line_q.push_back(ch);
        ch.char_out = 8'h0A;
        ch.last = 1'b1;
        line_q.push_back(ch);
    endfunction

    // driver: one word per request, random gap after each accepted word while send_idle is set
    always @(negedge clk or negedge rst_n)
    begin
        item_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left = 0;
        end
        else if (!s_tvalid || s_fire)
        begin
            if (s_fire)
                gap_left = send_idle ? $urandom_range(0, 4) : 0;
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (request_q.size() > 0)
            begin
                req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, req};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stall after each accepted character while recv_idle is set
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_fire)
                stall_left = recv_idle ? $urandom_range(0, 4) : 0;
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: check output words, predict on accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        char_t want;
        item_t req;
        if (!rst_n)
        begin
            s_fire <= 1'b0;
            m_fire <= 1'b0;
        end
        else
        begin
            s_fire <= s_tvalid && s_tready;
            m_fire <= m_tvalid && m_tready;
            if (m_tvalid && m_tready)
            begin
                chars_seen++;
                if (line_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, got char %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = line_q.pop_front();
                    if (m_tdata !== want.char_out)
                    begin
                        errors++;
                        $display("%0t: char_out expected %h got %h",
                                 $time, want.char_out, m_tdata);
                    end
                    if (m_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: last expected %b got %b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                req = item_t'(s_tdata[32:0]);
                if (req.mode == MODE_REG)
                    lines_reg++;
                else
                    lines_bit++;
                encode_line(req);
            end
        end
    end

    task automatic add_request(input logic mode, input logic [15:0] address,
                               input logic [15:0] value);
        item_t req;
        req.mode = mode;
        req.address = address;
        req.value = value;
        request_q.push_back(req);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || s_tvalid || line_q.size() != 0);
    endtask

    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        case ($urandom_range(0, 7))
            0:       w = 16'h0000;
            1:       w = 16'hFFFF;
            default: w = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return w;
    endfunction

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            add_request($urandom_range(0, 1) ? MODE_REG : MODE_BIT, pick_word(), pick_word());
    endtask

    initial
    begin
        // directed: field extremes, both modes, high value byte ignored in bit mode
        add_request(MODE_BIT, 16'h0000, 16'h0000);
        add_request(MODE_REG, 16'h0000, 16'h0000);
        add_request(MODE_BIT, 16'hFFFF, 16'hFFFF);
        add_request(MODE_REG, 16'hFFFF, 16'hFFFF);
        add_request(MODE_BIT, 16'h1234, 16'hFF00);
        add_request(MODE_BIT, 16'h1234, 16'h00FF);
        add_request(MODE_BIT, 16'h1234, 16'hAB5A);
        add_request(MODE_REG, 16'h5555, 16'hAAAA);
        add_request(MODE_REG, 16'hAAAA, 16'h5555);
        add_request(MODE_BIT, 16'h5555, 16'hAAAA);
        add_request(MODE_BIT, 16'hAAAA, 16'h5555);
        add_request(MODE_REG, 16'h8000, 16'h0001);
        add_request(MODE_REG, 16'h0001, 16'h8000);
        add_request(MODE_BIT, 16'h8000, 16'h0080);
        add_request(MODE_BIT, 16'h0001, 16'h0001);
        add_request(MODE_REG, 16'h00FF, 16'hFF00);
        add_request(MODE_REG, 16'hFF00, 16'h00FF);
        add_request(MODE_BIT, 16'h0A0F, 16'h009C);
        add_request(MODE_REG, 16'hBEEF, 16'hCAFE);
        add_request(MODE_REG, 16'h0000, 16'hFFFF);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // each phase waits until every expected character has arrived before the next is queued
        wait_drained();
        @(posedge clk);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        add_random(RANDOM_PER_PHASE);
        wait_drained();
        @(posedge clk);
        send_idle = 1'b1;
        recv_idle = 1'b0;
        add_random(RANDOM_PER_PHASE);
        wait_drained();
        @(posedge clk);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        add_random(RANDOM_PER_PHASE);
        wait_drained();
        @(posedge clk);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        add_random(RANDOM_PER_PHASE);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d bit-mode and %0d register-mode lines, %0d characters",
                 lines_bit, lines_reg, chars_seen);
        $display("with random gaps and stalls on both sides, back-to-back phases and drains");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mfhe_pkg.sv
rtl/core/mfhe_in_buf.sv
rtl/core/mfhe_char_gen.sv
rtl/core/mfhe_out_reg.sv
rtl/core/modbus_frame_hex_encoder.sv
rtl/core/mfhe_checker.sv
sim/tb_modbus_frame_hex_encoder.sv
